[rtl/hsns_pkg.sv]
// Shared types, constants and the neighbor stencil of the half-shell stencil block.
package hsns_pkg;

  localparam int AXIS_WIDTH = 10;
  localparam int IDX_W      = 30;
  localparam int PROD_W     = 2 * AXIS_WIDTH;
  localparam int NSLOTS     = 13;
  localparam int SLOT_W     = $clog2(NSLOTS);
  localparam int CFG_IDX_W  = 2;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_CELLS_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Z = CFG_IDX_W'(2);

  typedef enum logic [1:0] {OFF_ZERO, OFF_POS, OFF_NEG} off_t;

  typedef struct packed {
    off_t dx;
    off_t dy;
    off_t dz;
  } step_t;

  localparam step_t STENCIL [NSLOTS] = '{
    '{OFF_POS,  OFF_ZERO, OFF_ZERO},
    '{OFF_POS,  OFF_POS,  OFF_ZERO},
    '{OFF_POS,  OFF_POS,  OFF_POS },
    '{OFF_POS,  OFF_ZERO, OFF_POS },
    '{OFF_ZERO, OFF_POS,  OFF_ZERO},
    '{OFF_NEG,  OFF_POS,  OFF_ZERO},
    '{OFF_NEG,  OFF_POS,  OFF_POS },
    '{OFF_ZERO, OFF_POS,  OFF_POS },
    '{OFF_ZERO, OFF_ZERO, OFF_POS },
    '{OFF_NEG,  OFF_ZERO, OFF_POS },
    '{OFF_NEG,  OFF_NEG,  OFF_POS },
    '{OFF_ZERO, OFF_NEG,  OFF_POS },
    '{OFF_POS,  OFF_NEG,  OFF_POS }
  };

  typedef struct packed {
    logic [AXIS_WIDTH-1:0] cell_x;
    logic [AXIS_WIDTH-1:0] cell_y;
    logic [AXIS_WIDTH-1:0] cell_z;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  own_index;
    logic [IDX_W-1:0]  neighbor_index;
    logic [SLOT_W-1:0] stencil_slot;
    logic              none_found;
    logic              bad_cell;
    logic              last;
  } out_t;

  typedef struct packed {
    logic [AXIS_WIDTH-1:0] cells_x;
    logic [AXIS_WIDTH-1:0] cells_y;
    logic [AXIS_WIDTH-1:0] cells_z;
    logic [IDX_W-1:0]      cells_xy;
  } cfg_t;

  // One classified request waiting for the back end.
  typedef struct packed {
    logic [IDX_W-1:0]  own;
    logic [NSLOTS-1:0] mask;
    logic              bad;
  } entry_t;

endpackage

[rtl/hsns_front.sv]
// Front end: accepts requests, checks the coordinate and builds the own index and neighbor mask.
module hsns_front (
  input  logic            clk,
  input  logic            rst_n,
  input  hsns_pkg::cfg_t  cfg,
  input  logic            in_valid,
  output logic            in_stall,
  input  hsns_pkg::in_t   in_data,
  output logic            push,
  output hsns_pkg::entry_t push_data,
  input  logic            fifo_full
);
  import hsns_pkg::*;

  function automatic logic slot_ok(input off_t o, input logic p, input logic m);
    logic r;
    unique case (o)
      OFF_POS:  r = p;
      OFF_NEG:  r = m;
      OFF_ZERO: r = 1'b1;
      default:  r = 1'b0;
    endcase
    return r;
  endfunction

  logic              s1_v_r, s1_v_nxt;
  in_t               s1_r;
  logic              s1_bad_r;
  logic              s2_v_r, s2_v_nxt;
  logic [IDX_W-1:0]  s2_x_r, s2_ynx_r, s2_zxy_r;
  logic [NSLOTS-1:0] s2_mask_r;
  logic              s2_bad_r;

  logic              s1_free, s2_free, in_bad;
  logic              xp, xm, yp, ym, zp;
  logic [NSLOTS-1:0] mask;

  assign s2_free  = !s2_v_r || !fifo_full;
  assign s1_free  = !s1_v_r || s2_free;
  assign in_stall = !s1_free;

  assign in_bad = (in_data.cell_x >= cfg.cells_x) || (in_data.cell_y >= cfg.cells_y) ||
                  (in_data.cell_z >= cfg.cells_z);

  assign xp = ({1'b0, s1_r.cell_x} + 1'b1) < {1'b0, cfg.cells_x};
  assign yp = ({1'b0, s1_r.cell_y} + 1'b1) < {1'b0, cfg.cells_y};
  assign zp = ({1'b0, s1_r.cell_z} + 1'b1) < {1'b0, cfg.cells_z};
  assign xm = s1_r.cell_x != '0;
  assign ym = s1_r.cell_y != '0;

  always_comb begin
    for (int s = 0; s < NSLOTS; s++) begin
      // The stencil never steps backward in z.
      mask[s] = slot_ok(STENCIL[s].dx, xp, xm) && slot_ok(STENCIL[s].dy, yp, ym) &&
                slot_ok(STENCIL[s].dz, zp, 1'b0);
    end
  end

  assign s1_v_nxt = (in_valid && s1_free) || (s1_v_r && !s2_free);
  assign s2_v_nxt = s2_free ? s1_v_r : s2_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_free) begin
      s1_r     <= in_data;
      s1_bad_r <= in_bad;
    end
    if (s1_v_r && s2_free) begin
      s2_x_r    <= IDX_W'(s1_r.cell_x);
      s2_ynx_r  <= IDX_W'(s1_r.cell_y) * IDX_W'(cfg.cells_x);
      s2_zxy_r  <= IDX_W'(s1_r.cell_z) * cfg.cells_xy;
      s2_mask_r <= mask;
      s2_bad_r  <= s1_bad_r;
    end
  end

  assign push           = s2_v_r && !fifo_full;
  assign push_data.own  = s2_x_r + s2_ynx_r + s2_zxy_r;
  assign push_data.mask = s2_mask_r;
  assign push_data.bad  = s2_bad_r;

endmodule

[rtl/hsns_fifo.sv]
// Short queue of classified requests between the front end and the back end.
module hsns_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  hsns_pkg::entry_t push_data,
  input  logic             pop,
  output hsns_pkg::entry_t pop_data,
  output logic             full,
  output logic             empty
);
  import hsns_pkg::*;

  entry_t           mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   count_r, count_nxt;

  assign full     = count_r == (PTR_W+1)'(FIFO_DEPTH);
  assign empty    = count_r == '0;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

[rtl/hsns_back.sv]
// Back end: walks the neighbor mask of one request and emits one result per cycle unless out_stall holds the output.
module hsns_back (
  input  logic             clk,
  input  logic             rst_n,
  input  hsns_pkg::cfg_t   cfg,
  input  hsns_pkg::entry_t head,
  input  logic             fifo_empty,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output hsns_pkg::out_t   out_data
);
  import hsns_pkg::*;

  function automatic logic [IDX_W-1:0] term(input off_t o, input logic [IDX_W-1:0] v);
    logic [IDX_W-1:0] r;
    unique case (o)
      OFF_POS: r = v;
      OFF_NEG: r = ~v + 1'b1;
      default: r = '0;
    endcase
    return r;
  endfunction

  logic              work_v_r, work_v_nxt;
  entry_t            work_r;
  logic              out_v_r;
  out_t              out_r;

  logic              emit, done;
  logic [SLOT_W-1:0] sel;
  step_t             step;
  logic [NSLOTS-1:0] rem;
  logic [IDX_W-1:0]  nb;
  out_t              res;

  always_comb begin
    sel = '0;
    for (int i = NSLOTS - 1; i >= 0; i--) begin
      if (work_r.mask[i]) sel = SLOT_W'(i);
    end
  end

  assign step = STENCIL[sel];
  // Clearing the lowest set bit leaves the slots still to be sent.
  assign rem  = work_r.mask & (work_r.mask - NSLOTS'(1));
  assign nb   = work_r.own + term(step.dx, IDX_W'(1)) +
                term(step.dy, IDX_W'(cfg.cells_x)) + term(step.dz, cfg.cells_xy);

  always_comb begin
    res = '0;
    if (work_r.bad) begin
      res.bad_cell = 1'b1;
      res.last     = 1'b1;
    end else if (work_r.mask == '0) begin
      res.own_index  = work_r.own;
      res.none_found = 1'b1;
      res.last       = 1'b1;
    end else begin
      res.own_index      = work_r.own;
      res.neighbor_index = nb;
      res.stencil_slot   = sel;
      res.last           = rem == '0;
    end
  end

  assign emit       = work_v_r && (!out_v_r || !out_stall);
  assign done       = emit && res.last;
  assign pop        = !fifo_empty && (!work_v_r || done);
  assign work_v_nxt = pop || (work_v_r && !done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      work_v_r <= work_v_nxt;
      if (emit) out_v_r <= 1'b1;
      else if (!out_stall) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) work_r <= head;
    else if (emit) work_r.mask <= rem;
    if (emit) out_r <= res;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

[rtl/half_shell_neighbor_stencil_top.sv]
// Top level of the half-shell neighbor stencil: configuration registers, front, queue, back.
//
//   channel   direction  handshake               payload
//   in_       request    in_valid / in_stall     hsns_pkg::in_t  (cell_x, cell_y, cell_z)
//   out_      result     out_valid / out_stall   hsns_pkg::out_t (indices, slot, flags, last)
//   cfg_      write      cfg_valid / cfg_ready   cfg_index, cfg_data (cells_x, cells_y, cells_z)
//
// A request yields max(1, neighbors) results, at most 13; the back end's one-result-per-cycle
// walk of the neighbor mask, paused while out_stall holds the output, sets the sustained rate.
// The front end takes a request every cycle while in_stall is low, through two register stages
// into a four-entry queue; then come the back end's work register and the output register.
// Reset is synchronous and active low; every axis count resets to one.
// out_stall holds the output register and the back end; requests keep entering until the
// queue and both front stages are full, and only then does in_stall rise.
module half_shell_neighbor_stencil_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  hsns_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output hsns_pkg::out_t                      out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hsns_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hsns_pkg::AXIS_WIDTH-1:0]     cfg_data
);
  import hsns_pkg::*;

  logic [AXIS_WIDTH-1:0] cells_x_r, cells_y_r, cells_z_r;
  logic [IDX_W-1:0]      cells_xy_r;
  logic [PROD_W-1:0]     xy_prod;
  cfg_t                  cfg;

  logic                  push, pop, fifo_full, fifo_empty;
  entry_t                push_data, head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_x_r <= AXIS_WIDTH'(1);
      cells_y_r <= AXIS_WIDTH'(1);
      cells_z_r <= AXIS_WIDTH'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CELLS_X: cells_x_r <= cfg_data;
        REG_CELLS_Y: cells_y_r <= cfg_data;
        REG_CELLS_Z: cells_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // The plane size is registered from the x and y counts, so it lags a write to either of them.
  assign xy_prod = PROD_W'(cells_x_r) * PROD_W'(cells_y_r);

  always_ff @(posedge clk) begin
    cells_xy_r <= IDX_W'(xy_prod);
  end

  assign cfg.cells_x  = cells_x_r;
  assign cfg.cells_y  = cells_y_r;
  assign cfg.cells_z  = cells_z_r;
  assign cfg.cells_xy = cells_xy_r;

  hsns_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .fifo_full (fifo_full)
  );

  hsns_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (head),
    .full      (fifo_full),
    .empty     (fifo_empty)
  );

  hsns_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .head       (head),
    .fifo_empty (fifo_empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  // Within one request's run the next result follows at once, for the same cell, higher slot.
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last |=>
      out_valid && out_data.own_index == $past(out_data.own_index) &&
      out_data.stencil_slot > $past(out_data.stencil_slot))
    else $error("neighbor run broken or out of order");

  a_bad_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_cell |->
      out_data.last && !out_data.none_found && out_data.own_index == '0 &&
      out_data.neighbor_index == '0)
    else $error("bad cell result carries data");

  a_none_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.none_found |->
      out_data.last && !out_data.bad_cell && out_data.neighbor_index == '0 &&
      out_data.stencil_slot == '0)
    else $error("empty result carries a neighbor");

endmodule

[verif/testbench.sv]
// Self-checking testbench for the half-shell neighbor stencil top level.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hsns_pkg::*;

  // There is no register at this index, so a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);
  localparam int MAX_COORD = (1 << AXIS_WIDTH) - 1;

  // Forward half-shell offsets, in the order in which the block reports them.
  localparam int STEP_DX [13] = '{1, 1, 1, 1, 0, -1, -1, 0, 0, -1, -1, 0, 1};
  localparam int STEP_DY [13] = '{0, 1, 1, 0, 1, 1, 1, 1, 0, 0, -1, -1, -1};
  localparam int STEP_DZ [13] = '{0, 0, 1, 1, 0, 0, 1, 1, 1, 1, 1, 1, 1};

  class stencil_scoreboard;
    int   cnt_x = 1;
    int   cnt_y = 1;
    int   cnt_z = 1;
    out_t pending_results [$];
    int   mismatches = 0;

    function void set_count(logic [CFG_IDX_W-1:0] idx, logic [AXIS_WIDTH-1:0] val);
      case (idx)
        REG_CELLS_X: cnt_x = val;
        REG_CELLS_Y: cnt_y = val;
        REG_CELLS_Z: cnt_z = val;
        default: ;
      endcase
    endfunction

    function logic [IDX_W-1:0] cell_index(int x, int y, int z);
      longint unsigned v;
      v = longint'(x) + longint'(y) * cnt_x + longint'(z) * cnt_x * cnt_y;
      return v[IDX_W-1:0];
    endfunction

    function bit fits(int c, int d, int n);
      if (d < 0) return c > 0;
      if (d > 0) return c + 1 < n;
      return 1'b1;
    endfunction

    // Expands one accepted request into the run of results it must produce.
    function void predict_neighbors(in_t req);
      int   x, y, z, s;
      out_t r;
      out_t run [$];
      x = req.cell_x;
      y = req.cell_y;
      z = req.cell_z;
      r = '0;
      if (x >= cnt_x || y >= cnt_y || z >= cnt_z) begin
        r.bad_cell = 1'b1;
        r.last = 1'b1;
        pending_results.insert(pending_results.size(), r);
        return;
      end
      for (s = 0; s < 13; s++) begin
        if (fits(x, STEP_DX[s], cnt_x) && fits(y, STEP_DY[s], cnt_y) &&
            fits(z, STEP_DZ[s], cnt_z)) begin
          r = '0;
          r.own_index = cell_index(x, y, z);
          r.neighbor_index = cell_index(x + STEP_DX[s], y + STEP_DY[s], z + STEP_DZ[s]);
          r.stencil_slot = SLOT_W'(s);
          run.insert(run.size(), r);
        end
      end
      if (run.size() == 0) begin
        r = '0;
        r.own_index = cell_index(x, y, z);
        r.none_found = 1'b1;
        run.insert(run.size(), r);
      end
      r = run.pop_back();
      r.last = 1'b1;
      run.insert(run.size(), r);
      foreach (run[i]) pending_results.insert(pending_results.size(), run[i]);
    endfunction

    function void note_failure(string what, out_t want, out_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s: expected own=%0d nb=%0d slot=%0d none=%0b bad=%0b last=%0b",
                 $realtime, what, want.own_index, want.neighbor_index, want.stencil_slot,
                 want.none_found, want.bad_cell, want.last,
                 ", got own=%0d nb=%0d slot=%0d none=%0b bad=%0b last=%0b",
                 got.own_index, got.neighbor_index, got.stencil_slot, got.none_found,
                 got.bad_cell, got.last);
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending_results.size() == 0) begin
        note_failure("result with no request outstanding", '0, got);
        return;
      end
      want = pending_results.pop_front();
      if (got.own_index !== want.own_index || got.neighbor_index !== want.neighbor_index ||
          got.stencil_slot !== want.stencil_slot || got.none_found !== want.none_found ||
          got.bad_cell !== want.bad_cell || got.last !== want.last)
        note_failure("result mismatch", want, got);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  in_t                    in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_t                   out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [AXIS_WIDTH-1:0]  cfg_data = '0;

  stencil_scoreboard sb = new();
  bit hold_request = 1'b0;
  bit send_quiet = 1'b0;

  half_shell_neighbor_stencil_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) sb.check_result(out_data);
  end

  // Result side: random stalls, quiet stretches, and one long hold on demand.
  initial begin : receiver
    int left;
    int tick;
    bit quiet_rx;
    left = 0;
    tick = 0;
    quiet_rx = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      tick++;
      if (tick % 64 == 0) quiet_rx = ($urandom_range(0, 3) == 0);
      if (hold_request) begin
        hold_request = 1'b0;
        left = 160;
      end
      if (left > 0) begin
        out_stall <= 1'b1;
        left--;
      end else if (quiet_rx || $urandom_range(0, 9) < 6) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if ($urandom_range(0, 40) == 0) send_quiet = !send_quiet;
    if (send_quiet) return 0;
    r = $urandom_range(0, 9);
    if (r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(5, 25);
  endfunction

  // Mostly inside the grid, with the edges and the first cell past them favored.
  function automatic logic [AXIS_WIDTH-1:0] pick_coord(int n);
    int r;
    r = $urandom_range(0, 99);
    if (n == 0 || r < 6) return AXIS_WIDTH'($urandom_range(0, MAX_COORD));
    if (r < 16) return AXIS_WIDTH'(n - 1);
    if (r < 26) return '0;
    if (r < 30) return AXIS_WIDTH'(n);
    return AXIS_WIDTH'($urandom_range(0, n - 1));
  endfunction

  task automatic send_cell(input int x, input int y, input int z, input bit no_gap);
    in_t req;
    int  gap;
    req.cell_x = AXIS_WIDTH'(x);
    req.cell_y = AXIS_WIDTH'(y);
    req.cell_z = AXIS_WIDTH'(z);
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.predict_neighbors(req);
    if (!no_gap) begin
      gap = pick_gap();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= AXIS_WIDTH'(val);
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_count(idx, AXIS_WIDTH'(val));
  endtask

  // Stops offering requests until every predicted result has come back.
  task automatic settle();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (sb.pending_results.size() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (12) @(posedge clk);
  endtask

  task automatic run_phase(input int cx, input int cy, input int cz, input int items,
                           input bit squeeze);
    int k;
    settle();
    write_reg(REG_CELLS_X, cx);
    write_reg(REG_CELLS_Y, cy);
    write_reg(REG_CELLS_Z, cz);
    if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, $urandom_range(0, MAX_COORD));
    // The long receiver hold lets back-to-back requests fill the queue.
    if (squeeze) hold_request = 1'b1;
    for (k = 0; k < items; k++) begin
      send_cell(pick_coord(cx), pick_coord(cy), pick_coord(cz), squeeze && k < 24);
      if (k == items / 2) settle();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset grid is a single cell.
    send_cell(0, 0, 0, 1'b0);
    send_cell(1, 0, 0, 1'b0);
    send_cell(0, 0, 1, 1'b0);
    settle();

    write_reg(REG_CELLS_X, 4);
    write_reg(REG_CELLS_Y, 3);
    write_reg(REG_CELLS_Z, 5);
    write_reg(REG_UNUSED, 1);
    send_cell(0, 0, 0, 1'b0);
    send_cell(1, 1, 1, 1'b0);
    send_cell(3, 2, 4, 1'b0);
    send_cell(3, 0, 0, 1'b0);
    send_cell(0, 2, 0, 1'b0);
    send_cell(0, 0, 4, 1'b0);
    send_cell(3, 2, 0, 1'b0);
    send_cell(0, 2, 4, 1'b0);
    send_cell(4, 0, 0, 1'b0);
    send_cell(0, 3, 0, 1'b0);
    send_cell(0, 0, 5, 1'b0);
    send_cell(MAX_COORD, MAX_COORD, MAX_COORD, 1'b0);
    settle();

    write_reg(REG_CELLS_X, MAX_COORD);
    write_reg(REG_CELLS_Y, MAX_COORD);
    write_reg(REG_CELLS_Z, MAX_COORD);
    send_cell(0, 0, 0, 1'b0);
    send_cell(1022, 1022, 1022, 1'b0);
    send_cell(1021, 1021, 1021, 1'b0);
    send_cell(1022, 0, 1021, 1'b0);
    send_cell(MAX_COORD, 0, 0, 1'b0);
    send_cell(0, MAX_COORD, 0, 1'b0);
    send_cell(0, 0, MAX_COORD, 1'b0);
    send_cell(682, 341, 512, 1'b0);

    run_phase(MAX_COORD, MAX_COORD, MAX_COORD, 90, 1'b1);
    run_phase(1, 1, 1, 16, 1'b0);
    repeat (4)
      run_phase($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 6), 20, 1'b0);
    run_phase(0, 7, 7, 10, 1'b0);
    run_phase(7, 7, 0, 6, 1'b0);
    repeat (3)
      run_phase($urandom_range(1, MAX_COORD), $urandom_range(1, MAX_COORD),
                $urandom_range(1, MAX_COORD), 20, 1'b0);
    run_phase(2, MAX_COORD, 1, 20, 1'b0);
    run_phase(MAX_COORD, 1, 2, 20, 1'b0);
    run_phase(3, 3, MAX_COORD, 20, 1'b0);
    run_phase(MAX_COORD, MAX_COORD, MAX_COORD, 10, 1'b0);

    settle();
    if (sb.pending_results.size() != 0)
      $display("%0d expected results never arrived", sb.pending_results.size());
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

[files.f]
rtl/hsns_pkg.sv
rtl/hsns_front.sv
rtl/hsns_fifo.sv
rtl/hsns_back.sv
rtl/half_shell_neighbor_stencil_top.sv
verif/testbench.sv
